FILE: design/bb3_pkg.sv
// Shared types and constants of the 3x3 RGB box blur.
// Item structs, window control structs and the reciprocal table for the mean.
// No dependencies.
package bb3_pkg;

  localparam int PIX_W       = 8;
  localparam int FW_W        = 11;   // frame_width register
  localparam int FH_W        = 16;   // frame_height register
  localparam int ROW_W       = 16;   // output row position
  localparam int IN_ROW_W    = 17;   // input row runs one row past the frame while flushing
  localparam int SUM_W       = 12;   // nine 8-bit values
  localparam int CNT_W       = 4;    // up to nine pixels averaged
  localparam int NUM_W       = 13;   // 2*sum + count
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  // One line store entry: the pixel two rows up and the pixel one row up.
  typedef struct packed {
    pix_t top;
    pix_t mid;
  } line_pair_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } win_col_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic latch;
  } win_ctl_t;

  typedef struct packed {
    logic row_top;
    logic row_bot;
    logic col_left;
    logic col_right;
  } win_mask_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } chan_sum_t;

  // ceil(2^20 / (2*count)); exact floor division for any numerator below 2^13.
  function automatic logic [RECIP_W-1:0] bb3_recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      4'd1:    r = 20'd524288;
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd6:    r = 20'd87382;
      4'd9:    r = 20'd58255;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/box_blur_3x3_rgb.sv
// Streaming 3x3 box blur over RGB frames, edge pixels averaged over in-frame neighbors.
// One item at a time: an item with a result passes accept, line store read, window sum,
// multiply and output load, then sits in the output register, before the next item is taken;
// an item with no result ends after the line store read, an ignored item at its acceptance;
// a full output register under stall holds the block in the output step.
// Reset (async, active low): frame 640x480, positions and window cleared, no output pending.
module box_blur_3x3_rgb
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  localparam int AW = $clog2(MAX_WIDTH);      // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);  // effective width, up to MAX_WIDTH

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_e;

  state_e                state_q, state_d;
  logic                  out_valid_q;
  out_item_t             out_data_q;

  // configuration and frame positions
  logic [FW_W-1:0]       frame_width_q;
  logic [FH_W-1:0]       frame_height_q;
  logic [WW-1:0]         w_eff;
  logic [FH_W-1:0]       h_eff;
  logic [AW-1:0]         in_col_q;
  logic [IN_ROW_W-1:0]   in_row_q;
  logic [AW-1:0]         out_col_q;
  logic [ROW_W-1:0]      out_row_q;

  // item in flight
  logic                  act_q;
  pix_t                  pix_q;
  logic [AW-1:0]         wr_col_q;
  logic                  ready_q;
  logic                  fe_q;

  logic                  in_take;
  logic                  item_live;
  logic                  item_ready;
  logic                  cfg_hit;
  logic                  col_wrap_in;
  logic                  col_wrap_out;
  logic                  frame_done;
  logic                  restart;
  logic                  out_load;

  line_pair_t            mem_rd;
  line_pair_t            mem_wr;
  win_col_t              win_col;
  win_ctl_t              win_ctl;
  win_mask_t             win_mask;
  chan_sum_t             win_sum;
  logic [CNT_W-1:0]      win_cnt;
  pix_t                  mean;

  // Clamp the registers to the range the datapath supports.
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_q);
    end
  end
  assign h_eff = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;

  // A pixel past the last row waits for frame_end and is dropped; a flush counts
  // only once every pixel of the frame has arrived and outputs remain.
  assign in_take   = in_valid_i && (state_q == ST_IDLE);
  assign item_live = in_take &&
                     ((in_data_i.action == ACT_PIXEL) ?
                      (in_row_q < IN_ROW_W'(h_eff)) :
                      ((in_row_q >= IN_ROW_W'(h_eff)) && (out_row_q < h_eff)));

  // The output lags the input by one row plus one pixel.
  assign item_ready  = (in_row_q >= IN_ROW_W'(2)) ||
                       ((in_row_q == IN_ROW_W'(1)) && (in_col_q != '0));
  assign col_wrap_in = (32'(in_col_q) + 32'd1) >= 32'(w_eff);

  assign col_wrap_out = (32'(out_col_q) + 32'd1) >= 32'(w_eff);
  assign frame_done   = col_wrap_out &&
                        ((IN_ROW_W'(out_row_q) + IN_ROW_W'(1)) >= IN_ROW_W'(h_eff));

  assign cfg_hit = cfg_we_i &&
                   ((cfg_idx_i == CFG_FRAME_WIDTH) || (cfg_idx_i == CFG_FRAME_HEIGHT));
  assign restart = cfg_hit || ((state_q == ST_SUM) && frame_done);

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_live) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // items in the first row plus one pixel only prime the window
        state_d = ready_q ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and output register; the output register holds while stalled and the
  // block takes the next item meanwhile.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q          <= 1'b1;
        out_data_q.out_red   <= mean.red;
        out_data_q.out_green <= mean.green;
        out_data_q.out_blue  <= mean.blue;
        out_data_q.frame_end <= fe_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration and frame position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_W'(640);
      frame_height_q <= FH_W'(480);
      in_col_q       <= '0;
      in_row_q       <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_FRAME_WIDTH)) begin
        frame_width_q <= cfg_data_i[FW_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == CFG_FRAME_HEIGHT)) begin
        frame_height_q <= cfg_data_i[FH_W-1:0];
      end
      if (restart) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        if (item_live) begin
          if (col_wrap_in) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + IN_ROW_W'(1);
          end else begin
            in_col_q <= in_col_q + AW'(1);
          end
        end
        if (state_q == ST_SUM) begin
          if (col_wrap_out) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + ROW_W'(1);
          end else begin
            out_col_q <= out_col_q + AW'(1);
          end
        end
      end
    end
  end

  // Hold the accepted item while its line store entry is read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= ACT_PIXEL;
      ready_q  <= 1'b0;
      fe_q     <= 1'b0;
      pix_q    <= '0;
      wr_col_q <= '0;
    end else begin
      if (item_live) begin
        act_q       <= in_data_i.action;
        ready_q     <= item_ready;
        pix_q.red   <= in_data_i.in_red;
        pix_q.green <= in_data_i.in_green;
        pix_q.blue  <= in_data_i.in_blue;
        wr_col_q    <= in_col_q;
      end
      if (state_q == ST_SUM) begin
        fe_q <= frame_done;
      end
    end
  end

  // Rotate the column entry: the middle row moves up, the new pixel becomes the middle.
  assign mem_wr.top = mem_rd.mid;
  assign mem_wr.mid = pix_q;

  bb3_line_mem #(
    .DEPTH(MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (item_live),
    .rd_addr_i (in_col_q),
    .wr_en_i   ((state_q == ST_READ) && (act_q == ACT_PIXEL)),
    .wr_addr_i (wr_col_q),
    .wr_data_i (mem_wr),
    .rd_data_o (mem_rd)
  );

  // A flush feeds zero into the bottom row; it lies below the frame and is masked.
  assign win_col.top = mem_rd.top;
  assign win_col.mid = mem_rd.mid;
  assign win_col.bot = (act_q == ACT_PIXEL) ? pix_q : '0;

  assign win_ctl.clear = restart;
  assign win_ctl.shift = (state_q == ST_READ);
  assign win_ctl.latch = (state_q == ST_SUM);

  assign win_mask.row_top   = (out_row_q != '0);
  assign win_mask.row_bot   = (IN_ROW_W'(out_row_q) + IN_ROW_W'(1)) < IN_ROW_W'(h_eff);
  assign win_mask.col_left  = (out_col_q != '0);
  assign win_mask.col_right = !col_wrap_out;

  bb3_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (win_ctl),
    .col_i  (win_col),
    .mask_i (win_mask),
    .sum_o  (win_sum),
    .cnt_o  (win_cnt)
  );

  bb3_div u_div (
    .clk_i  (clk_i),
    .load_i (state_q == ST_MUL),
    .sum_i  (win_sum),
    .cnt_i  (win_cnt),
    .pix_o  (mean)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: design/bb3_line_mem.sv
// Line store of the box blur: one entry per column holding the two rows above.
// Synchronous read into an output register, one write port. Uses bb3_pkg.
module bb3_line_mem
  import bb3_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  line_pair_t               wr_data_i,
  output line_pair_t               rd_data_o
);

  line_pair_t mem_q [DEPTH];
  line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/bb3_window.sv
// 3x3 neighborhood window of the box blur with masked per-channel sums.
// Shifts in one column per item and registers the in-frame sum and count. Uses bb3_pkg.
module bb3_window
  import bb3_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  win_ctl_t         ctl_i,
  input  win_col_t         col_i,
  input  win_mask_t        mask_i,
  output chan_sum_t        sum_o,
  output logic [CNT_W-1:0] cnt_o
);

  pix_t             win_q [3][3];
  pix_t             col_in [3];
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  chan_sum_t        sum_d;
  chan_sum_t        sum_q;
  logic [CNT_W-1:0] cnt_d;
  logic [CNT_W-1:0] cnt_q;

  assign col_in[0] = col_i.top;
  assign col_in[1] = col_i.mid;
  assign col_in[2] = col_i.bot;
  assign row_ok    = {mask_i.row_bot, 1'b1, mask_i.row_top};
  assign col_ok    = {mask_i.col_right, 1'b1, mask_i.col_left};

  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          sum_d.red   = sum_d.red   + SUM_W'(win_q[r][c].red);
          sum_d.green = sum_d.green + SUM_W'(win_q[r][c].green);
          sum_d.blue  = sum_d.blue  + SUM_W'(win_q[r][c].blue);
          cnt_d       = cnt_d + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (ctl_i.clear) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (ctl_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
        win_q[r][2] <= col_in[r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign sum_o = sum_q;
  assign cnt_o = cnt_q;

endmodule

FILE: design/bb3_div.sv
// Rounded mean of the box blur: (2*sum + count) / (2*count) per channel.
// Multiplies by a table reciprocal and takes the high bits. Uses bb3_pkg.
module bb3_div
  import bb3_pkg::*;
(
  input  logic             clk_i,
  input  logic             load_i,
  input  chan_sum_t        sum_i,
  input  logic [CNT_W-1:0] cnt_i,
  output pix_t             pix_o
);

  logic [RECIP_W-1:0] recip;
  logic [NUM_W-1:0]   num_red;
  logic [NUM_W-1:0]   num_green;
  logic [NUM_W-1:0]   num_blue;
  logic [PROD_W-1:0]  prod_red_q;
  logic [PROD_W-1:0]  prod_green_q;
  logic [PROD_W-1:0]  prod_blue_q;

  assign recip     = bb3_recip(cnt_i);
  assign num_red   = {sum_i.red, 1'b0}   + NUM_W'(cnt_i);
  assign num_green = {sum_i.green, 1'b0} + NUM_W'(cnt_i);
  assign num_blue  = {sum_i.blue, 1'b0}  + NUM_W'(cnt_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_red_q   <= PROD_W'(num_red)   * PROD_W'(recip);
      prod_green_q <= PROD_W'(num_green) * PROD_W'(recip);
      prod_blue_q  <= PROD_W'(num_blue)  * PROD_W'(recip);
    end
  end

  assign pix_o.red   = prod_red_q[RECIP_SHIFT +: PIX_W];
  assign pix_o.green = prod_green_q[RECIP_SHIFT +: PIX_W];
  assign pix_o.blue  = prod_blue_q[RECIP_SHIFT +: PIX_W];

endmodule

FILE: verif/tb_box_blur_3x3_rgb.sv
// Self-checking testbench of the streaming 3x3 RGB box blur, top box_blur_3x3_rgb.
// Predicts every blurred pixel from its own line stores and window, checks results in order.
// Depends on bb3_pkg and the RTL of box_blur_3x3_rgb.
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgb;
  import bb3_pkg::*;

  localparam int unsigned MAX_W        = 1024;
  localparam int unsigned RESET_CYCLES = 12;
  // Let the last item finish its path through the block before a register write.
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned RANDOM_ITEMS = 300;

  // Indexes past the register list: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;

  box_blur_3x3_rgb u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Blur predictor: shadow registers, two line stores, 3x3 window, positions.
  // ---------------------------------------------------------------------------
  int unsigned width_reg;
  int unsigned height_reg;
  pix_t        line_two_up [MAX_W];
  pix_t        line_one_up [MAX_W];
  pix_t        nbhd [9];           // row-major: top row 0..2, middle 3..5, bottom 6..8
  int unsigned in_col, in_row;     // position of the next incoming item
  int unsigned out_col, out_row;   // position of the next blurred pixel

  out_item_t   blurred_q [$];      // blurred pixels still to come out of the block
  int unsigned err_count = 0;

  // Shared idling controls: idle_on turns random gaps and stalls on for both sides,
  // hold_req asks the receiver for one long hold-off.
  bit          idle_on = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned stall_run = 0;
  int unsigned cycle_cnt = 0;

  // Out-of-range sizes: width 0 acts as 1, above MAX_W as MAX_W; height 0 acts as 1.
  function automatic int unsigned eff_w();
    return (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // Drop the window and all positions; line stores keep their contents.
  function automatic void restart_positions();
    for (int k = 0; k < 9; k++) nbhd[k] = '0;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // Shift the window one column left and load the new right column.
  function automatic void shift_nbhd(input pix_t top, input pix_t mid, input pix_t bot);
    pix_t fresh [3];
    fresh[0] = top;
    fresh[1] = mid;
    fresh[2] = bot;
    for (int k = 0; k < 3; k++) begin
      nbhd[k*3]     = nbhd[k*3+1];
      nbhd[k*3+1]   = nbhd[k*3+2];
      nbhd[k*3+2]   = fresh[k];
    end
  endfunction

  // Advance the predictor by one accepted item; returns 1 when it yields a pixel.
  function automatic bit blur_step(input in_item_t it, output out_item_t res);
    int unsigned w, h, col, cnt;
    int unsigned acc [3];
    bit          ready;
    bit          row_in [3];
    bit          col_in [3];
    pix_t        top, mid, px;
    w   = eff_w();
    h   = eff_h();
    col = in_col;
    res = '0;
    if (col >= w) col = 0;

    if (it.action == ACT_PIXEL) begin
      // A pixel past the end of the frame waits for frame_end and is dropped.
      if (in_row >= h) return 1'b0;
      px  = {it.in_red, it.in_green, it.in_blue};
      top = line_two_up[col];
      mid = line_one_up[col];
      line_two_up[col] = mid;
      line_one_up[col] = px;
      shift_nbhd(top, mid, px);
    end else begin
      // A flush only counts once every pixel of the frame is in.
      if (in_row < h || out_row >= h) return 1'b0;
      shift_nbhd(line_two_up[col], line_one_up[col], '0);
    end

    // Output lags the input by one row plus one pixel.
    ready = (in_row >= 2) || (in_row == 1 && col >= 1);
    in_col = col + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!ready) return 1'b0;

    // Average only the neighbors that lie inside the frame.
    row_in[0] = out_row > 0;
    row_in[1] = 1'b1;
    row_in[2] = out_row + 1 < h;
    col_in[0] = out_col > 0;
    col_in[1] = 1'b1;
    col_in[2] = out_col + 1 < w;
    acc[0] = 0;
    acc[1] = 0;
    acc[2] = 0;
    cnt    = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_in[r] && col_in[c]) begin
          acc[0] += 32'(nbhd[r*3+c].red);
          acc[1] += 32'(nbhd[r*3+c].green);
          acc[2] += 32'(nbhd[r*3+c].blue);
          cnt++;
        end
      end
    end
    // Round half up.
    res.out_red   = PIX_W'((2 * acc[0] + cnt) / (2 * cnt));
    res.out_green = PIX_W'((2 * acc[1] + cnt) / (2 * cnt));
    res.out_blue  = PIX_W'((2 * acc[2] + cnt) / (2 * cnt));

    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) begin
        res.frame_end = 1'b1;
        restart_positions();
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones, none when idling is off.
  function automatic int unsigned tx_gap();
    int unsigned sel;
    if (!idle_on) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 65) return 0;
    if (sel < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Lean on the channel extremes so saturation and zero sums show up often.
  function automatic logic [PIX_W-1:0] rand_chan();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  // Offer one item and hold it until accepted. Valid stays high into the next call,
  // so back-to-back items never toggle it within a time step.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    out_item_t   res;
    gap = tx_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (blur_step(it, res)) blurred_q.push_back(res);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                            input logic [PIX_W-1:0] blue);
    in_item_t it;
    it.action   = ACT_PIXEL;
    it.in_red   = red;
    it.in_green = green;
    it.in_blue  = blue;
    send_item(it);
  endtask

  // Color fields of a flush are don't-care; fill them with noise.
  task automatic send_flush();
    in_item_t it;
    it.action   = ACT_FLUSH;
    it.in_red   = PIX_W'($urandom);
    it.in_green = PIX_W'($urandom);
    it.in_blue  = PIX_W'($urandom);
    send_item(it);
  endtask

  // Drop valid, wait for every predicted pixel, then let the pipe run dry.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; only call while the block is idle. The trailing edge keeps
  // back-to-back writes from stacking two assignments of the enable in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_FRAME_WIDTH) begin
      width_reg = 32'(data) & ((32'd1 << FW_W) - 1);
      restart_positions();
    end else if (idx == CFG_FRAME_HEIGHT) begin
      height_reg = 32'(data) & ((32'd1 << FH_W) - 1);
      restart_positions();
    end
  endtask

  // One whole frame of random pixels and its flush tail. With noise, mix in early
  // flushes, surplus pixels before frame_end and spare flushes after it, all dropped.
  task automatic send_frame(input bit noisy);
    int unsigned w, h;
    w = eff_w();
    h = eff_h();
    for (int unsigned n = 0; n < w * h; n++) begin
      if (noisy && $urandom_range(0, 29) == 0) send_flush();
      send_pixel(rand_chan(), rand_chan(), rand_chan());
    end
    for (int unsigned n = 0; n <= w; n++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_pixel(rand_chan(), rand_chan(), rand_chan());
      send_flush();
    end
    if (noisy && $urandom_range(0, 3) == 0) send_flush();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry is 640 wide: the first blurred pixels appear after 641 items.
  task automatic test_reset_geometry();
    idle_on = 1'b1;
    repeat (MAX_W - 378) send_pixel(rand_chan(), rand_chan(), rand_chan());
    settle();
  endtask

  // Single pixel frame from zero sizes, unused register indexes mid-frame, rounding at
  // the extremes, single row frame whose first flush yields nothing.
  task automatic test_corner_cases();
    idle_on = 1'b1;
    write_reg(CFG_FRAME_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 0);
    send_flush();                          // early flush: dropped
    send_pixel('1, '1, '1);
    send_pixel('0, '0, '0);                // frame already full: dropped
    send_flush();
    send_flush();                          // last pixel out with frame_end
    settle();

    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 2);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd0,   8'd255, 8'd1);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    settle();
    // Writes past the register list must not restart the frame.
    write_reg(CFG_UNUSED_A, 16'hFFFF);
    write_reg(CFG_UNUSED_B, 16'h0001);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd255, 8'd0,   8'd255);
    repeat (4) send_flush();
    settle();

    write_reg(CFG_FRAME_HEIGHT, 1);
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1,   8'd128, 8'd254);
    repeat (4) send_flush();
    settle();
  endtask

  // Widest row by clamping in the tallest frame, then a single column.
  task automatic test_size_extremes();
    idle_on = 1'b1;
    // All ones in the width register clamp to the widest row; cut short after a few outputs.
    write_reg(CFG_FRAME_WIDTH, 16'hFFFF);
    write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
    repeat (MAX_W + 6) send_pixel(rand_chan(), rand_chan(), rand_chan());
    settle();
    // One column, tallest frame: every output but the first has rows above and below.
    write_reg(CFG_FRAME_WIDTH, 1);
    repeat (40) send_pixel(rand_chan(), rand_chan(), rand_chan());
    settle();
  endtask

  // Hold the output for a long stretch while items keep coming, so the block fills up
  // and must stall its input.
  task automatic test_backpressure();
    write_reg(CFG_FRAME_WIDTH, 6);
    write_reg(CFG_FRAME_HEIGHT, 4);
    idle_on  = 1'b0;
    hold_req = 400;
    send_frame(1'b0);
    settle();
    idle_on = 1'b1;
  endtask

  // Bulk of the run: random geometries, mostly small, whole frames with random content,
  // some noise and now and then a frame cut short by the next register write.
  task automatic test_random_frames();
    int unsigned done, sel, w, h, k;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 10)      w = $urandom_range(1, 2);
      else if (sel < 85) w = $urandom_range(3, 12);
      else if (sel < 97) w = $urandom_range(13, 64);
      else               w = $urandom_range(65, 200);
      if (w > 64)                          h = $urandom_range(1, 2);
      else if ($urandom_range(0, 6) == 0)  h = 1;
      else                                 h = $urandom_range(2, 8);

      settle();
      // A size of one is sometimes written as zero.
      if ($urandom_range(0, 1) != 0) begin
        write_reg(CFG_FRAME_WIDTH, (w == 1 && $urandom_range(0, 1) != 0) ? 0 : w);
        write_reg(CFG_FRAME_HEIGHT, (h == 1 && $urandom_range(0, 1) != 0) ? 0 : h);
      end else begin
        write_reg(CFG_FRAME_HEIGHT, (h == 1 && $urandom_range(0, 1) != 0) ? 0 : h);
        write_reg(CFG_FRAME_WIDTH, (w == 1 && $urandom_range(0, 1) != 0) ? 0 : w);
      end

      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(1, w * h + w);
        for (int unsigned n = 0; n < k; n++) begin
          if ($urandom_range(0, 9) == 0) send_flush();
          else send_pixel(rand_chan(), rand_chan(), rand_chan());
        end
        done += k;
      end else begin
        send_frame(1'b1);
        done += w * h + w + 1;
      end
    end
    settle();
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall runs, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : rx_stall
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!idle_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 30) begin
      stall_run   = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Compare each accepted pixel with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (blurred_q.size() == 0) begin
        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d end=%0b", $time,
                 out_data_o.out_red, out_data_o.out_green, out_data_o.out_blue,
                 out_data_o.frame_end);
        err_count++;
      end else begin
        want = blurred_q.pop_front();
        check_field("out_red",   want.out_red,   out_data_o.out_red);
        check_field("out_green", want.out_green, out_data_o.out_green);
        check_field("out_blue",  want.out_blue,  out_data_o.out_blue);
        check_field("frame_end", want.frame_end, out_data_o.frame_end);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d pixels still pending", $time, blurred_q.size());
      $display("box_blur_3x3_rgb: mismatch");
      $finish;
    end
  end

  initial begin : run_tests
    width_reg  = 640;
    height_reg = 480;
    for (int k = 0; k < MAX_W; k++) begin
      line_two_up[k] = '0;
      line_one_up[k] = '0;
    end
    restart_positions();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    test_reset_geometry();
    test_corner_cases();
    test_size_extremes();
    test_backpressure();
    test_random_frames();

    settle();
    if (err_count == 0) begin
      $display("box_blur_3x3_rgb: match");
    end else begin
      $display("box_blur_3x3_rgb: mismatch");
    end
    $finish;
  end

endmodule
